FILE: hw/rtl/mpdr_pkg.sv
// Shared types and constants for the mod-p dense row cancel core.
// No dependencies; used by the controller, the datapath and the top level.
package mpdr_pkg;

    localparam int VAL_W = 15;
    localparam int COL_W = 12;
    localparam int POS_W = 13;
    localparam int PROD_W = 2 * VAL_W;
    localparam int RCNT_W = 5;

    localparam logic [VAL_W-1:0] MODULUS_RST = 15'd32749;
    localparam logic [VAL_W-1:0] MIN_PRIME = 15'd2;

    localparam logic [2:0] MODE_WRITE = 3'd0;
    localparam logic [2:0] MODE_CANCEL = 3'd1;
    localparam logic [2:0] MODE_SCAN = 3'd2;
    localparam logic [2:0] MODE_CLEAR = 3'd3;
    localparam logic [2:0] MODE_READ = 3'd4;

    localparam logic [1:0] KIND_ENTRY = 2'd0;
    localparam logic [1:0] KIND_POS = 2'd1;
    localparam logic [1:0] KIND_MULT = 2'd2;

    typedef enum logic [4:0] {
        ST_INIT, ST_IDLE, ST_CG, ST_CW, ST_RD, ST_RDW, ST_EW, ST_MSET,
        ST_AG, ST_AW, ST_MUL, ST_PG, ST_PW, ST_WB, ST_SCAN, ST_SCHK,
        ST_CLR, ST_OUT
    } state_t;

    typedef enum logic [1:0] {OPND_COEFF, OPND_MEM, OPND_MULT, OPND_PROD} opnd_t;
    typedef enum logic [2:0] {LAT_NONE, LAT_C, LAT_E, LAT_A, LAT_P} latch_t;
    typedef enum logic [1:0] {WD_ZERO, WD_C, WD_CANCEL} wsel_t;

    typedef struct packed {
        logic   accept;
        logic   red_start;
        opnd_t  opnd;
        latch_t latch;
        logic   mult_set;
        logic   mul;
        logic   mem_re;
        logic   mem_we;
        logic   use_idx;
        wsel_t  wsel;
        logic   idx_inc;
        logic   idx_end1;
        logic   out_load;
    } cmd_t;

    typedef struct packed {
        logic       red_done;
        logic       idx_past_end;
        logic       idx_in_row;
        logic       idx_last_row;
        logic       hit;
        logic       out_free;
        logic [2:0] mode;
        logic       first;
        logic       last;
    } status_t;

endpackage

FILE: hw/rtl/mpdr_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module mpdr_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hw/rtl/mpdr_datapath.sv
// Datapath: row RAM, bit-serial mod-p reducer, multiplier, counters, result register.
// Depends on mpdr_pkg and mpdr_ram.
module mpdr_datapath #(
    parameter int ROW_LEN = 4096
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  mpdr_pkg::cmd_t               cmd,
    output mpdr_pkg::status_t            sts,
    input  logic                         cfg_valid,
    input  logic [mpdr_pkg::VAL_W-1:0]   cfg_wdata,
    input  logic [2:0]                   s_mode,
    input  logic [mpdr_pkg::COL_W-1:0]   s_column,
    input  logic [mpdr_pkg::COL_W-1:0]   s_range_end,
    input  logic [mpdr_pkg::VAL_W-1:0]   s_coeff,
    input  logic                         s_first_of_row,
    input  logic                         s_last_of_row,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [1:0]                   m_result_kind,
    output logic [mpdr_pkg::VAL_W-1:0]   m_value,
    output logic [mpdr_pkg::POS_W-1:0]   m_position
);

    localparam int AW = $clog2(ROW_LEN);
    localparam int IW = (AW + 1 > mpdr_pkg::POS_W) ? AW + 1 : mpdr_pkg::POS_W;
    localparam int VW = mpdr_pkg::VAL_W;
    localparam logic [IW-1:0] ROW_LEN_W = IW'(ROW_LEN);
    localparam logic [IW-1:0] ROW_LAST_W = IW'(ROW_LEN - 1);

    logic [VW-1:0] modulus_reg;
    logic [2:0] mode_reg;
    logic [mpdr_pkg::COL_W-1:0] col_reg, end_reg;
    logic [VW-1:0] coeff_reg;
    logic first_reg, last_reg;
    logic [IW-1:0] idx_reg;
    logic [VW-1:0] c_reg, e_reg, a_reg, pm_reg, mult_reg;
    logic [mpdr_pkg::PROD_W-1:0] prod_reg;
    logic [VW-1:0] red_acc_reg;
    logic [mpdr_pkg::PROD_W-1:0] red_x_reg;
    logic [mpdr_pkg::RCNT_W-1:0] red_cnt_reg;
    logic m_valid_reg;
    logic [1:0] kind_reg;
    logic [VW-1:0] value_reg;
    logic [mpdr_pkg::POS_W-1:0] pos_reg;

    logic [VW-1:0] p_eff, rdata, mem_val, opnd, wdata, neg_a, neg_e;
    logic [IW-1:0] col_ext, end_ext, addr_ext;
    logic col_ok, we;
    logic [VW:0] red_t, red_sub, wb_sum;

    assign p_eff = (modulus_reg < mpdr_pkg::MIN_PRIME) ? mpdr_pkg::MIN_PRIME : modulus_reg;
    assign col_ext = {{(IW - mpdr_pkg::COL_W){1'b0}}, col_reg};
    assign end_ext = {{(IW - mpdr_pkg::COL_W){1'b0}}, end_reg};
    assign col_ok = col_ext < ROW_LEN_W;
    assign addr_ext = cmd.use_idx ? idx_reg : col_ext;
    assign mem_val = col_ok ? rdata : '0;
    assign neg_a = (a_reg == '0) ? '0 : p_eff - a_reg;
    assign neg_e = (e_reg == '0) ? '0 : p_eff - e_reg;

    // e - prod mod p, both already reduced
    assign wb_sum = (e_reg >= pm_reg) ? {1'b0, e_reg - pm_reg}
                                      : {1'b0, e_reg} + {1'b0, p_eff} - {1'b0, pm_reg};

    always_comb begin
        case (cmd.wsel)
            mpdr_pkg::WD_C:      wdata = c_reg;
            mpdr_pkg::WD_CANCEL: wdata = wb_sum[VW-1:0];
            default:             wdata = '0;
        endcase
    end

    assign we = cmd.mem_we && (cmd.use_idx ? (idx_reg < ROW_LEN_W) : col_ok);

    mpdr_ram #(.WIDTH(VW), .DEPTH(ROW_LEN)) u_row (
        .clk   (aclk),
        .we    (we),
        .waddr (addr_ext[AW-1:0]),
        .wdata (wdata),
        .re    (cmd.mem_re),
        .raddr (addr_ext[AW-1:0]),
        .rdata (rdata)
    );

    always_comb begin
        case (cmd.opnd)
            mpdr_pkg::OPND_COEFF: opnd = coeff_reg;
            mpdr_pkg::OPND_MEM:   opnd = mem_val;
            default:              opnd = mult_reg;
        endcase
    end

    // one restoring step: shift in next bit, subtract p once
    assign red_t = {red_acc_reg, red_x_reg[mpdr_pkg::PROD_W-1]};
    assign red_sub = red_t - {1'b0, p_eff};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg <= mpdr_pkg::MODULUS_RST;
            mult_reg <= '0;
            idx_reg <= '0;
            red_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                modulus_reg <= cfg_wdata;
            end
            if (cmd.accept) begin
                mode_reg <= s_mode;
                col_reg <= s_column;
                end_reg <= s_range_end;
                coeff_reg <= s_coeff;
                first_reg <= s_first_of_row;
                last_reg <= s_last_of_row;
                idx_reg <= {{(IW - mpdr_pkg::COL_W){1'b0}}, s_column};
            end else if (cmd.idx_end1) begin
                idx_reg <= end_ext + IW'(1);
            end else if (cmd.idx_inc) begin
                idx_reg <= idx_reg + IW'(1);
            end
            if (cmd.red_start) begin
                red_acc_reg <= '0;
                if (cmd.opnd == mpdr_pkg::OPND_PROD) begin
                    red_x_reg <= prod_reg;
                    red_cnt_reg <= mpdr_pkg::RCNT_W'(mpdr_pkg::PROD_W);
                end else begin
                    red_x_reg <= {opnd, {VW{1'b0}}};
                    red_cnt_reg <= mpdr_pkg::RCNT_W'(VW);
                end
            end else if (red_cnt_reg != '0) begin
                red_acc_reg <= red_sub[VW] ? red_t[VW-1:0] : red_sub[VW-1:0];
                red_x_reg <= red_x_reg << 1;
                red_cnt_reg <= red_cnt_reg - mpdr_pkg::RCNT_W'(1);
            end
            case (cmd.latch)
                mpdr_pkg::LAT_C: c_reg <= red_acc_reg;
                mpdr_pkg::LAT_E: e_reg <= red_acc_reg;
                mpdr_pkg::LAT_A: a_reg <= red_acc_reg;
                mpdr_pkg::LAT_P: pm_reg <= red_acc_reg;
                default: ;
            endcase
            if (cmd.mult_set) begin
                mult_reg <= (c_reg == VW'(1)) ? e_reg : neg_e;
            end
            if (cmd.mul) begin
                prod_reg <= mpdr_pkg::PROD_W'(a_reg) * mpdr_pkg::PROD_W'(c_reg);
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            case (mode_reg)
                mpdr_pkg::MODE_READ: begin
                    kind_reg <= mpdr_pkg::KIND_ENTRY;
                    value_reg <= mem_val;
                    pos_reg <= {1'b0, col_reg};
                end
                mpdr_pkg::MODE_CANCEL: begin
                    kind_reg <= mpdr_pkg::KIND_MULT;
                    value_reg <= neg_a;
                    pos_reg <= '0;
                end
                default: begin
                    kind_reg <= mpdr_pkg::KIND_POS;
                    value_reg <= '0;
                    pos_reg <= idx_reg[mpdr_pkg::POS_W-1:0];
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_result_kind = kind_reg;
    assign m_value = value_reg;
    assign m_position = pos_reg;

    assign sts.red_done = (red_cnt_reg == '0);
    assign sts.idx_past_end = idx_reg > end_ext;
    assign sts.idx_in_row = idx_reg < ROW_LEN_W;
    assign sts.idx_last_row = idx_reg == ROW_LAST_W;
    assign sts.hit = rdata != '0;
    assign sts.out_free = !m_valid_reg || m_ready;
    assign sts.mode = mode_reg;
    assign sts.first = first_reg;
    assign sts.last = last_reg;

endmodule

FILE: hw/rtl/mpdr_ctrl.sv
// Controller state machine sequencing the datapath for each operation.
// Depends on mpdr_pkg.
module mpdr_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic [2:0]        s_mode,
    output logic              s_ready,
    input  mpdr_pkg::status_t sts,
    output mpdr_pkg::cmd_t    cmd
);

    mpdr_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mpdr_pkg::ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mpdr_pkg::ST_INIT: if (sts.idx_last_row) state_next = mpdr_pkg::ST_IDLE;
            mpdr_pkg::ST_IDLE: begin
                if (s_valid) begin
                    case (s_mode)
                        mpdr_pkg::MODE_WRITE,
                        mpdr_pkg::MODE_CANCEL: state_next = mpdr_pkg::ST_CG;
                        mpdr_pkg::MODE_READ:   state_next = mpdr_pkg::ST_RD;
                        mpdr_pkg::MODE_SCAN:   state_next = mpdr_pkg::ST_SCAN;
                        mpdr_pkg::MODE_CLEAR:  state_next = mpdr_pkg::ST_CLR;
                        default:               state_next = mpdr_pkg::ST_IDLE;
                    endcase
                end
            end
            mpdr_pkg::ST_CG: state_next = mpdr_pkg::ST_CW;
            mpdr_pkg::ST_CW: begin
                if (sts.red_done) begin
                    state_next = (sts.mode == mpdr_pkg::MODE_WRITE) ? mpdr_pkg::ST_WB
                                                                    : mpdr_pkg::ST_RD;
                end
            end
            mpdr_pkg::ST_RD: state_next = mpdr_pkg::ST_RDW;
            mpdr_pkg::ST_RDW: begin
                state_next = (sts.mode == mpdr_pkg::MODE_READ) ? mpdr_pkg::ST_OUT
                                                               : mpdr_pkg::ST_EW;
            end
            mpdr_pkg::ST_EW: begin
                if (sts.red_done) begin
                    state_next = sts.first ? mpdr_pkg::ST_MSET : mpdr_pkg::ST_AG;
                end
            end
            mpdr_pkg::ST_MSET: state_next = mpdr_pkg::ST_AG;
            mpdr_pkg::ST_AG: state_next = mpdr_pkg::ST_AW;
            mpdr_pkg::ST_AW: if (sts.red_done) state_next = mpdr_pkg::ST_MUL;
            mpdr_pkg::ST_MUL: state_next = mpdr_pkg::ST_PG;
            mpdr_pkg::ST_PG: state_next = mpdr_pkg::ST_PW;
            mpdr_pkg::ST_PW: if (sts.red_done) state_next = mpdr_pkg::ST_WB;
            mpdr_pkg::ST_WB: begin
                state_next = (sts.mode == mpdr_pkg::MODE_CANCEL && sts.last)
                           ? mpdr_pkg::ST_OUT : mpdr_pkg::ST_IDLE;
            end
            mpdr_pkg::ST_SCAN: begin
                state_next = (sts.idx_past_end || !sts.idx_in_row) ? mpdr_pkg::ST_OUT
                                                                   : mpdr_pkg::ST_SCHK;
            end
            mpdr_pkg::ST_SCHK: state_next = sts.hit ? mpdr_pkg::ST_OUT : mpdr_pkg::ST_SCAN;
            mpdr_pkg::ST_CLR: begin
                if (sts.idx_past_end || !sts.idx_in_row) state_next = mpdr_pkg::ST_IDLE;
            end
            mpdr_pkg::ST_OUT: if (sts.out_free) state_next = mpdr_pkg::ST_IDLE;
            default: state_next = mpdr_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        s_ready = 1'b0;
        case (state_reg)
            mpdr_pkg::ST_INIT: begin
                cmd.mem_we = 1'b1;
                cmd.use_idx = 1'b1;
                cmd.wsel = mpdr_pkg::WD_ZERO;
                cmd.idx_inc = 1'b1;
            end
            mpdr_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                cmd.accept = s_valid;
            end
            mpdr_pkg::ST_CG: begin
                cmd.red_start = 1'b1;
                cmd.opnd = mpdr_pkg::OPND_COEFF;
            end
            mpdr_pkg::ST_CW: if (sts.red_done) cmd.latch = mpdr_pkg::LAT_C;
            mpdr_pkg::ST_RD: cmd.mem_re = 1'b1;
            mpdr_pkg::ST_RDW: begin
                if (sts.mode != mpdr_pkg::MODE_READ) begin
                    cmd.red_start = 1'b1;
                    cmd.opnd = mpdr_pkg::OPND_MEM;
                end
            end
            mpdr_pkg::ST_EW: if (sts.red_done) cmd.latch = mpdr_pkg::LAT_E;
            mpdr_pkg::ST_MSET: cmd.mult_set = 1'b1;
            mpdr_pkg::ST_AG: begin
                cmd.red_start = 1'b1;
                cmd.opnd = mpdr_pkg::OPND_MULT;
            end
            mpdr_pkg::ST_AW: if (sts.red_done) cmd.latch = mpdr_pkg::LAT_A;
            mpdr_pkg::ST_MUL: cmd.mul = 1'b1;
            mpdr_pkg::ST_PG: begin
                cmd.red_start = 1'b1;
                cmd.opnd = mpdr_pkg::OPND_PROD;
            end
            mpdr_pkg::ST_PW: if (sts.red_done) cmd.latch = mpdr_pkg::LAT_P;
            mpdr_pkg::ST_WB: begin
                cmd.mem_we = 1'b1;
                cmd.wsel = (sts.mode == mpdr_pkg::MODE_WRITE) ? mpdr_pkg::WD_C
                                                              : mpdr_pkg::WD_CANCEL;
            end
            mpdr_pkg::ST_SCAN: begin
                cmd.use_idx = 1'b1;
                if (sts.idx_past_end || !sts.idx_in_row) begin
                    cmd.idx_end1 = 1'b1;
                end else begin
                    cmd.mem_re = 1'b1;
                end
            end
            mpdr_pkg::ST_SCHK: if (!sts.hit) cmd.idx_inc = 1'b1;
            mpdr_pkg::ST_CLR: begin
                if (!sts.idx_past_end && sts.idx_in_row) begin
                    cmd.mem_we = 1'b1;
                    cmd.use_idx = 1'b1;
                    cmd.wsel = mpdr_pkg::WD_ZERO;
                    cmd.idx_inc = 1'b1;
                end
            end
            mpdr_pkg::ST_OUT: cmd.out_load = sts.out_free;
            default: ;
        endcase
    end

endmodule

FILE: hw/rtl/mod_p_dense_row_sparse_cancel_core.sv
// Top level of the mod-p dense row cancel core: controller plus datapath.
// Depends on mpdr_pkg, mpdr_ctrl, mpdr_datapath (and mpdr_ram below it).
//
//  channel | direction | handshake            | payload
//  s_      | in        | s_valid / s_ready    | mode, column, range_end, coeff, first/last_of_row
//  m_      | out       | m_valid / m_ready    | result_kind, value, position
//  cfg_    | in        | cfg_valid / cfg_ready| wdata = modulus p
//
// Each item is taken in the idle state. Write runs one bit-serial mod-p reduction and a
// write-back; read reads the row RAM; cancel runs reductions of 15, 15, 15 and 30 steps
// with a read, a multiply and a write-back, sets the multiplier on a lead element and
// returns its negation on the last one; scan reads and checks each column in turn until
// a hit or the end of the range; clear zeroes each column of the range; unused modes give no result.
// After reset the row RAM is zeroed one entry per cycle, every entry in turn, with
// s_ready low; configuration transfers are taken at any time.
// A finished result waits in the output register; the next item proceeds and only
// stalls when it needs that register while m_ready is low.
module mod_p_dense_row_sparse_cancel_core #(
    parameter int ROW_LEN = 4096
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [mpdr_pkg::VAL_W-1:0] cfg_wdata,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [2:0]                 s_mode,
    input  logic [mpdr_pkg::COL_W-1:0] s_column,
    input  logic [mpdr_pkg::COL_W-1:0] s_range_end,
    input  logic [mpdr_pkg::VAL_W-1:0] s_coeff,
    input  logic                       s_first_of_row,
    input  logic                       s_last_of_row,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [1:0]                 m_result_kind,
    output logic [mpdr_pkg::VAL_W-1:0] m_value,
    output logic [mpdr_pkg::POS_W-1:0] m_position
);

    mpdr_pkg::cmd_t    cmd;
    mpdr_pkg::status_t sts;

    // modulus register is always writable
    assign cfg_ready = 1'b1;

    mpdr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_mode  (s_mode),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    mpdr_datapath #(.ROW_LEN(ROW_LEN)) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .cfg_valid      (cfg_valid),
        .cfg_wdata      (cfg_wdata),
        .s_mode         (s_mode),
        .s_column       (s_column),
        .s_range_end    (s_range_end),
        .s_coeff        (s_coeff),
        .s_first_of_row (s_first_of_row),
        .s_last_of_row  (s_last_of_row),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_kind  (m_result_kind),
        .m_value        (m_value),
        .m_position     (m_position)
    );

endmodule

FILE: dv/mod_p_dense_row_sparse_cancel_core_tb.sv
// Self-checking testbench for mod_p_dense_row_sparse_cancel_core.
// Depends on mpdr_pkg and the core RTL; a behavioral row mirror predicts every result.
module mod_p_dense_row_sparse_cancel_core_tb;

    localparam int ROWS = 4096;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE = 4500;      // covers a full-row clear, which gives no result
    localparam logic [2:0] MODE_NOP5 = 3'd5;
    localparam logic [2:0] MODE_NOP6 = 3'd6;
    localparam logic [2:0] MODE_NOP7 = 3'd7;

    typedef struct packed {
        logic [2:0]                 mode;
        logic [mpdr_pkg::COL_W-1:0] col;
        logic [mpdr_pkg::COL_W-1:0] rend;
        logic [mpdr_pkg::VAL_W-1:0] coeff;
        logic                       first;
        logic                       last;
    } op_t;

    typedef struct packed {
        logic [1:0]                 kind;
        logic [mpdr_pkg::VAL_W-1:0] value;
        logic [mpdr_pkg::POS_W-1:0] position;
    } res_t;

    logic aclk = 1'b0;
    logic aresetn;
    logic cfg_valid, cfg_ready;
    logic [mpdr_pkg::VAL_W-1:0] cfg_wdata;
    logic s_valid, s_ready;
    logic [2:0] s_mode;
    logic [mpdr_pkg::COL_W-1:0] s_column, s_range_end;
    logic [mpdr_pkg::VAL_W-1:0] s_coeff;
    logic s_first_of_row, s_last_of_row;
    logic m_valid, m_ready;
    logic [1:0] m_result_kind;
    logic [mpdr_pkg::VAL_W-1:0] m_value;
    logic [mpdr_pkg::POS_W-1:0] m_position;

    // mirror of the block state
    logic [mpdr_pkg::VAL_W-1:0] row_mirror [ROWS];
    logic [mpdr_pkg::VAL_W-1:0] mult_mirror;
    logic [mpdr_pkg::VAL_W-1:0] modulus_mirror;

    res_t pending_q[$];
    int   errors = 0;
    int   cycles = 0;
    int   last_base = 0;
    logic tx_quiet = 1'b0;    // sender offers back to back
    logic rx_quiet = 1'b0;    // receiver always ready
    logic rx_hold = 1'b0;     // long receiver stall
    int   rx_gap = 0;

    mod_p_dense_row_sparse_cancel_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_mode(s_mode), .s_column(s_column),
        .s_range_end(s_range_end), .s_coeff(s_coeff), .s_first_of_row(s_first_of_row),
        .s_last_of_row(s_last_of_row),
        .m_valid(m_valid), .m_ready(m_ready), .m_result_kind(m_result_kind),
        .m_value(m_value), .m_position(m_position)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Watchdog: no correct run comes near this.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("[mod_p_dense_row_sparse_cancel_core] ERROR");
            $finish;
        end
    end

    // Receiver: random gap after each result, unless quiet or held off.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_gap <= 0;
        end else if (rx_hold) begin
            m_ready <= 1'b0;
        end else if (m_valid && m_ready) begin
            int g;
            g = rx_quiet ? 0 : $urandom_range(0, 4);
            rx_gap <= g;
            m_ready <= (g == 0);
        end else if (rx_gap > 0) begin
            rx_gap <= rx_gap - 1;
            m_ready <= (rx_gap == 1);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Result checker: every transfer on m_ against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result kind=%0d value=%0d position=%0d",
                         $time, m_result_kind, m_value, m_position);
                errors++;
            end else begin
                res_t want;
                want = pending_q.pop_front();
                if (m_result_kind !== want.kind) begin
                    $display("%0t: kind expected %0d actual %0d", $time, want.kind,
                             m_result_kind);
                    errors++;
                end
                if (m_value !== want.value) begin
                    $display("%0t: value expected %0d actual %0d", $time, want.value, m_value);
                    errors++;
                end
                if (m_position !== want.position) begin
                    $display("%0t: position expected %0d actual %0d", $time, want.position,
                             m_position);
                    errors++;
                end
            end
        end
    end

    // Row mirror update for one accepted item; queues the result if any.
    task automatic predict_row_op(input op_t op);
        int p, c, e, a, prod, pos;
        res_t r;
        p = (modulus_mirror < 2) ? 2 : int'(modulus_mirror);
        c = int'(op.coeff) % p;
        case (op.mode)
            mpdr_pkg::MODE_WRITE: row_mirror[op.col] = mpdr_pkg::VAL_W'(c);
            mpdr_pkg::MODE_CANCEL: begin
                e = int'(row_mirror[op.col]) % p;
                if (op.first) begin
                    a = e;
                    if (c != 1) a = (p - a) % p;
                    mult_mirror = mpdr_pkg::VAL_W'(a);
                end
                a = int'(mult_mirror) % p;
                prod = (a * c) % p;
                row_mirror[op.col] = mpdr_pkg::VAL_W'((e + p - prod) % p);
                if (op.last) begin
                    r.kind = mpdr_pkg::KIND_MULT;
                    r.value = mpdr_pkg::VAL_W'((p - a) % p);
                    r.position = '0;
                    pending_q.insert(pending_q.size(), r);
                end
            end
            mpdr_pkg::MODE_SCAN: begin
                pos = int'(op.rend) + 1;
                for (int i = op.col; i <= op.rend; i++) begin
                    if (row_mirror[i] != 0) begin
                        pos = i;
                        break;
                    end
                end
                r.kind = mpdr_pkg::KIND_POS;
                r.value = '0;
                r.position = mpdr_pkg::POS_W'(pos);
                pending_q.insert(pending_q.size(), r);
            end
            mpdr_pkg::MODE_CLEAR: begin
                for (int i = op.col; i <= op.rend; i++) row_mirror[i] = '0;
            end
            mpdr_pkg::MODE_READ: begin
                r.kind = mpdr_pkg::KIND_ENTRY;
                r.value = row_mirror[op.col];
                r.position = mpdr_pkg::POS_W'(op.col);
                pending_q.insert(pending_q.size(), r);
            end
            default: ;
        endcase
    endtask

    // One transfer on s_. Valid is only lowered when a gap is drawn.
    task automatic send_op(input op_t op);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_mode <= op.mode;
        s_column <= op.col;
        s_range_end <= op.rend;
        s_coeff <= op.coeff;
        s_first_of_row <= op.first;
        s_last_of_row <= op.last;
        do @(posedge aclk); while (!s_ready);
        predict_row_op(op);
    endtask

    task automatic send(input logic [2:0] mode, input int col, input int rend,
                        input int coeff, input logic first, input logic last);
        op_t op;
        op.mode = mode;
        op.col = mpdr_pkg::COL_W'(col);
        op.rend = mpdr_pkg::COL_W'(rend);
        op.coeff = mpdr_pkg::VAL_W'(coeff);
        op.first = first;
        op.last = last;
        send_op(op);
    endtask

    // valid drops at the accepting edge, so the last item is not taken twice
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_q.size() != 0) @(posedge aclk);
    endtask

    // Modulus is changed only with the core idle.
    task automatic set_modulus(input int p);
        drain_results();
        repeat (SETTLE) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_wdata <= mpdr_pkg::VAL_W'(p);
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        modulus_mirror = mpdr_pkg::VAL_W'(p);
    endtask

    // Extremes, every mode, lead/no-lead cancels, empty ranges, unused modes.
    task automatic test_directed();
        send(mpdr_pkg::MODE_WRITE, 0, 0, 32767, 1'b0, 1'b0);        // reduced before storing
        send(mpdr_pkg::MODE_WRITE, 4095, 0, 32748, 1'b0, 1'b0);
        send(mpdr_pkg::MODE_READ, 0, 0, 0, 1'b0, 1'b0);
        send(mpdr_pkg::MODE_READ, 4095, 0, 0, 1'b0, 1'b0);
        send(mpdr_pkg::MODE_CANCEL, 4095, 0, 1, 1'b1, 1'b0);        // lead coefficient one
        send(mpdr_pkg::MODE_CANCEL, 0, 0, 32767, 1'b0, 1'b1);
        send(mpdr_pkg::MODE_WRITE, 100, 0, 12345, 1'b0, 1'b0);
        send(mpdr_pkg::MODE_CANCEL, 100, 0, 777, 1'b1, 1'b1);       // lead not one: negated
        send(mpdr_pkg::MODE_CANCEL, 4095, 0, 5, 1'b0, 1'b1);        // no lead: held multiplier
        send(mpdr_pkg::MODE_SCAN, 0, 4095, 0, 1'b1, 1'b1);
        send(mpdr_pkg::MODE_SCAN, 10, 9, 0, 1'b0, 1'b0);            // empty range
        send(mpdr_pkg::MODE_SCAN, 4095, 4095, 0, 1'b0, 1'b0);       // position 4095
        send(mpdr_pkg::MODE_CLEAR, 200, 100, 0, 1'b0, 1'b0);        // empty clear
        send(mpdr_pkg::MODE_CLEAR, 0, 4095, 0, 1'b0, 1'b0);
        send(mpdr_pkg::MODE_READ, 0, 0, 0, 1'b0, 1'b0);
        send(MODE_NOP5, 1, 2, 3, 1'b1, 1'b1);
        send(MODE_NOP6, 5, 5, 5, 1'b0, 1'b1);
        send(MODE_NOP7, 4095, 4095, 32767, 1'b1, 1'b1);
        send(mpdr_pkg::MODE_SCAN, 0, 4095, 0, 1'b0, 1'b0);
    endtask

    task automatic test_random(input int count);
        int done, r, len, col, p;
        done = 0;
        while (done < count) begin
            if ($urandom_range(0, 63) == 0) tx_quiet = ~tx_quiet;
            if ($urandom_range(0, 63) == 0) rx_quiet <= ~rx_quiet;
            r = $urandom_range(0, 99);
            if (r < 45) begin
                // well-formed sparse row, seeded at its lead column half the time
                last_base = $urandom_range(0, 4095);
                len = $urandom_range(1, 6);
                if ($urandom_range(0, 1)) begin
                    send(mpdr_pkg::MODE_WRITE, last_base, 0, $urandom_range(0, 32767),
                         1'b0, 1'b0);
                    done++;
                end
                for (int k = 0; k < len; k++) begin
                    col = (k == 0) ? last_base : (last_base + $urandom_range(0, 60)) % ROWS;
                    p = (k == 0 && $urandom_range(0, 1)) ? 1 : $urandom_range(0, 32767);
                    send(mpdr_pkg::MODE_CANCEL, col, $urandom_range(0, 4095), p, k == 0,
                         k == len - 1);
                end
                done += len;
            end else if (r < 60) begin
                send(mpdr_pkg::MODE_WRITE, $urandom_range(0, 4095), $urandom_range(0, 4095),
                     $urandom_range(0, 32767), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
                done++;
            end else if (r < 72) begin
                col = $urandom_range(0, 1) ? $urandom_range(0, 4095)
                                           : (last_base + $urandom_range(0, 60)) % ROWS;
                send(mpdr_pkg::MODE_READ, col, 0, 0, 1'b0, 1'b0);
                done++;
            end else if (r < 82) begin
                col = $urandom_range(0, 1) ? last_base : $urandom_range(0, 4095);
                if ($urandom_range(0, 39) == 0)
                    send(mpdr_pkg::MODE_SCAN, 0, 4095, 0, 1'b0, 1'b0);
                else if ($urandom_range(0, 19) == 0)
                    send(mpdr_pkg::MODE_SCAN, col, $urandom_range(0, col), 0, 1'b0, 1'b0);
                else
                    send(mpdr_pkg::MODE_SCAN, col, (col + $urandom_range(0, 40) > 4095) ? 4095
                         : col + $urandom_range(0, 40), 0, 1'b0, 1'b0);
                done++;
            end else if (r < 88) begin
                col = $urandom_range(0, 4095);
                send(mpdr_pkg::MODE_CLEAR, col, (col + $urandom_range(0, 20)) % ROWS, 0,
                     1'b0, 1'b0);
                done++;
            end else if (r < 95) begin
                // broken sequence: flags at random
                send(mpdr_pkg::MODE_CANCEL, $urandom_range(0, 4095), 0,
                     $urandom_range(0, 32767), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
                done++;
            end else begin
                send(3'($urandom_range(MODE_NOP5, MODE_NOP7)), $urandom_range(0, 4095),
                     $urandom_range(0, 4095), $urandom_range(0, 32767),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    // Stale entries and tiny moduli, including values below two.
    task automatic test_modulus_changes();
        set_modulus(7);
        send(mpdr_pkg::MODE_READ, 4095, 0, 0, 1'b0, 1'b0);
        send(mpdr_pkg::MODE_WRITE, 1, 0, 32767, 1'b0, 1'b0);
        send(mpdr_pkg::MODE_CANCEL, 4095, 0, 8, 1'b1, 1'b1);
        test_random(200);
        set_modulus(0);
        send(mpdr_pkg::MODE_WRITE, 2, 0, 3, 1'b0, 1'b0);
        send(mpdr_pkg::MODE_CANCEL, 2, 0, 1, 1'b1, 1'b1);
        set_modulus(1);
        test_random(100);
        set_modulus(2);
        test_random(100);
        set_modulus(32767);
        test_random(100);
    endtask

    // Receiver held off while the sender keeps offering: the core must stall s_.
    task automatic test_backpressure();
        tx_quiet = 1'b1;
        fork
            begin
                rx_hold <= 1'b1;
                repeat (3000) @(posedge aclk);
                rx_hold <= 1'b0;
            end
            begin
                for (int k = 0; k < 30; k++) send(mpdr_pkg::MODE_READ,
                                                  $urandom_range(0, 4095), 0, 0,
                                                  1'b0, 1'b0);
            end
        join
        tx_quiet = 1'b0;
    endtask

    // Sender pauses until everything has come back, then resumes.
    task automatic test_drain_pause();
        test_random(100);
        drain_results();
        test_random(100);
    endtask

    initial begin
        aresetn <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_wdata <= '0;
        s_valid <= 1'b0;
        s_mode <= mpdr_pkg::MODE_WRITE;
        s_column <= '0;
        s_range_end <= '0;
        s_coeff <= '0;
        s_first_of_row <= 1'b0;
        s_last_of_row <= 1'b0;
        for (int i = 0; i < ROWS; i++) row_mirror[i] = '0;
        mult_mirror = '0;
        modulus_mirror = mpdr_pkg::MODULUS_RST;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_backpressure();
        set_modulus(32749);
        test_random(800);
        test_drain_pause();
        test_modulus_changes();

        drain_results();
        repeat (SETTLE) @(posedge aclk);
        if (errors == 0)
            $display("[mod_p_dense_row_sparse_cancel_core] OK");
        else
            $display("[mod_p_dense_row_sparse_cancel_core] ERROR");
        $finish;
    end

endmodule
